// ===== sv/lzbt_pkg.sv =====
// ----------------------------------------------------------------------------
// lzbt_pkg: shared types and constants for the LZ77 byte-token encoder
// Holds the token format codes, default sizes, the controller states and the
// candidate token that travels along the match cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package lzbt_pkg;

  localparam int WINDOW_BYTES_DEF    = 4096;
  localparam int LOOKAHEAD_BYTES_DEF = 18;
  localparam int MIN_RUN             = 3;

  // Offsets go out as at most two bytes in the long token form.
  localparam int OFF_W = 16;

  localparam logic [7:0] HDR_MAGIC  = 8'h01;
  localparam logic [7:0] LIT_ESC    = 8'h80;
  localparam logic [7:0] SHORT_BASE = 8'h81;
  localparam logic [7:0] LONG_MARK  = 8'hFF;
  localparam int SHORT_MAX_OFF = 255;
  localparam int SHORT_MAX_LEN = 15;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR,
    S_CHECK,
    S_LOAD,
    S_SCAN,
    S_PICK,
    S_EMIT,
    S_FIN
  } state_t;

  // Candidate match run moving from cell to cell.
  typedef struct packed {
    logic             alive;
    logic [OFF_W-1:0] off;
  } token_t;

endpackage

`default_nettype wire

// ===== sv/lzbt_cell.sv =====
// ----------------------------------------------------------------------------
// lzbt_cell: one match cell
// Holds one target byte, extends the candidate run handed in by its lower
// neighbor and records the first (oldest) candidate that reaches it.
// ----------------------------------------------------------------------------
`default_nettype none

module lzbt_cell
  import lzbt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             clear,
  input  wire logic             shift_en,
  input  wire logic [7:0]       shift_in,
  output logic      [7:0]       tgt,
  input  wire logic             en,
  input  wire logic             b_valid,
  input  wire logic [7:0]       b,
  input  wire token_t           tok_in,
  output token_t                tok_out,
  output logic                  found,
  output logic      [OFF_W-1:0] found_off
);

  logic             hit;
  logic             run_alive;
  logic [OFF_W-1:0] run_off;

  assign hit     = tok_in.alive && (b == tgt);
  assign tok_out = '{alive: run_alive, off: run_off};

  always_ff @(posedge clk) begin
    if (shift_en) begin
      tgt <= shift_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      run_alive <= 1'b0;
      found     <= 1'b0;
    end else if (b_valid) begin
      run_alive <= hit;
      if (hit && en && !found) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid) begin
      run_off <= tok_in.off;
      if (hit && en && !found) begin
        found_off <= tok_in.off;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/lzbt_row.sv =====
// ----------------------------------------------------------------------------
// lzbt_row: row of match cells and best-match pick
// Cell j compares the streamed window byte against target byte j; runs move
// up one cell per cycle. The highest cell that saw a run gives the length.
// ----------------------------------------------------------------------------
`default_nettype none

module lzbt_row
  import lzbt_pkg::*;
#(
  parameter int LOOKAHEAD_BYTES = LOOKAHEAD_BYTES_DEF,
  localparam int LW = $clog2(LOOKAHEAD_BYTES + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             clear,
  input  wire logic             shift_en,
  input  wire logic [7:0]       shift_in,
  input  wire logic [LW-1:0]    maxlen,
  input  wire logic             b_valid,
  input  wire logic [7:0]       b,
  input  wire token_t           inject,
  output logic      [7:0]       lit_byte,
  output logic                  best_any,
  output logic      [LW-1:0]    best_len,
  output logic      [OFF_W-1:0] best_off
);

  logic   [7:0]       tgt   [LOOKAHEAD_BYTES];
  token_t             tok   [LOOKAHEAD_BYTES];
  logic               found [LOOKAHEAD_BYTES];
  logic   [OFF_W-1:0] foff  [LOOKAHEAD_BYTES];

  for (genvar j = 0; j < LOOKAHEAD_BYTES; j++) begin : g_cell
    lzbt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .clear     (clear),
      .shift_en  (shift_en),
      .shift_in  ((j == LOOKAHEAD_BYTES - 1) ? shift_in : tgt[(j + 1) % LOOKAHEAD_BYTES]),
      .tgt       (tgt[j]),
      .en        (LW'(j) < maxlen),
      .b_valid   (b_valid),
      .b         (b),
      .tok_in    ((j == 0) ? inject : tok[(j + LOOKAHEAD_BYTES - 1) % LOOKAHEAD_BYTES]),
      .tok_out   (tok[j]),
      .found     (found[j]),
      .found_off (foff[j])
    );
  end

  assign lit_byte = tgt[0];

  // Highest cell wins; its first hit is the oldest run of that length.
  always_comb begin
    best_any = 1'b0;
    best_len = '0;
    best_off = '0;
    for (int j = MIN_RUN - 1; j < LOOKAHEAD_BYTES; j++) begin
      if (found[j]) begin
        best_any = 1'b1;
        best_len = LW'(j + 1);
        best_off = foff[j];
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/lz77_byte_token_encoder_core.sv =====
// ----------------------------------------------------------------------------
// lz77_byte_token_encoder_core: greedy LZ77 byte-token encoder
// Takes uncompressed bytes, keeps a sliding window, and emits a header and
// literal / short match / long match tokens with the longest, oldest match.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid / tready        tdata[7:0] = in_byte
//  m_axis    out  tvalid / tready        tdata[7:0] = out_byte, tlast = run_last,
//                                        tuser[0] = stream_end
//  cfg       in   cfg_we                 cfg_wdata[31:0] = stream_length
//
//  Each coded token loads the lookahead into the cell row, then scans the
//  window (skipped at position zero), then emits its token bytes; the window
//  bytes stream through the cell row one per cycle from the single read port
//  of the byte ring.
//  Reset (rst, synchronous) clears control state; the ring needs no clearing.
//  A stalled output holds one byte in the output register and one pending.
//
`default_nettype none

module lz77_byte_token_encoder_core
  import lzbt_pkg::*;
#(
  parameter int WINDOW_BYTES    = WINDOW_BYTES_DEF,
  parameter int LOOKAHEAD_BYTES = LOOKAHEAD_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,      // stream_length
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic             m_axis_tlast,   // run_last
  output logic      [0:0]  m_axis_tuser    // [0] stream_end
);

  localparam int AW     = $clog2(WINDOW_BYTES + LOOKAHEAD_BYTES);
  localparam int RING_N = 1 << AW;
  localparam int CW     = $clog2(WINDOW_BYTES + LOOKAHEAD_BYTES + 1);
  localparam int OW     = $clog2(WINDOW_BYTES + 1);
  localparam int LW     = $clog2(LOOKAHEAD_BYTES + 1);

  state_t state, state_next;

  logic [31:0] stream_length;
  logic [31:0] hdr_len;
  logic [31:0] received;
  logic [31:0] code_pos;
  logic        final_q;

  logic [7:0]    ring [RING_N];
  logic [AW-1:0] rd_addr;
  logic          rd_en;
  logic [7:0]    rd_data;
  logic          rd_valid;

  logic [CW-1:0] ctr;
  logic [CW-1:0] ctr_d;
  logic [OW-1:0] n_q;
  logic [LW-1:0] maxlen_q;
  logic [31:0]   start_q;
  logic [CW-1:0] scan_end;

  logic [7:0] tok [4];
  logic [2:0] tok_n;
  logic [1:0] tok_i;

  logic       pend_valid;
  logic [7:0] pend_data;
  logic       out_free;
  logic       push_ok;
  logic       push_fire;
  logic [7:0] push_data;
  logic       fin_fire;

  logic [31:0] avail;
  logic        go;
  logic        accept;

  logic             row_clear;
  token_t           inject;
  logic [7:0]       lit_byte;
  logic             best_any;
  logic [LW-1:0]    best_len;
  logic [OFF_W-1:0] best_off;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign avail    = received - code_pos;
  assign go       = final_q ? (avail != 32'd0) : (avail >= 32'(LOOKAHEAD_BYTES));
  assign scan_end = CW'(n_q) + CW'(maxlen_q) - CW'(1);
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign push_ok  = !pend_valid || out_free;

  // -------- next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && received < stream_length) begin
          state_next = (received == 32'd0) ? S_HDR : S_CHECK;
        end
      end
      S_HDR: begin
        if (push_ok && ctr == CW'(4)) state_next = S_CHECK;
      end
      S_CHECK: state_next = go ? S_LOAD : S_FIN;
      S_LOAD: begin
        if (ctr == CW'(LOOKAHEAD_BYTES)) state_next = (n_q == '0) ? S_PICK : S_SCAN;
      end
      S_SCAN: begin
        if (ctr == scan_end) state_next = S_PICK;
      end
      S_PICK: state_next = S_EMIT;
      S_EMIT: begin
        if (push_ok && 3'(tok_i) == tok_n - 3'd1) state_next = S_CHECK;
      end
      S_FIN: begin
        if (!pend_valid || out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // -------- control outputs
  always_comb begin
    s_axis_tready = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    push_fire     = 1'b0;
    push_data     = tok[tok_i];
    fin_fire      = 1'b0;
    row_clear     = 1'b0;
    unique case (state)
      S_IDLE:  s_axis_tready = 1'b1;
      S_HDR: begin
        push_fire = push_ok;
        unique case (ctr[2:0])
          3'd0:    push_data = HDR_MAGIC;
          3'd1:    push_data = hdr_len[31:24];
          3'd2:    push_data = hdr_len[23:16];
          3'd3:    push_data = hdr_len[15:8];
          default: push_data = hdr_len[7:0];
        endcase
      end
      S_CHECK: row_clear = 1'b1;
      S_LOAD: begin
        rd_en   = ctr < CW'(LOOKAHEAD_BYTES);
        rd_addr = AW'(code_pos + 32'(ctr));
      end
      S_SCAN: begin
        rd_en   = ctr < scan_end;
        rd_addr = AW'(start_q + 32'(ctr));
      end
      S_PICK:  ;
      S_EMIT:  push_fire = push_ok;
      S_FIN:   fin_fire  = pend_valid && out_free;
      default: ;
    endcase
  end

  // -------- byte ring: every received byte lands at its stream position
  always_ff @(posedge clk) begin
    if (accept && received < stream_length) begin
      ring[AW'(received)] <= s_axis_tdata;
    end
    if (rd_en) begin
      rd_data <= ring[rd_addr];
    end
  end

  // -------- control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      stream_length <= 32'd1;
      received      <= '0;
      code_pos      <= '0;
      final_q       <= 1'b0;
      rd_valid      <= 1'b0;
      ctr           <= '0;
      tok_i         <= '0;
      pend_valid    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= rd_en;
      if (cfg_we) stream_length <= cfg_wdata;

      if (state == S_IDLE && accept && received < stream_length) begin
        received <= received + 32'd1;
        final_q  <= (received + 32'd1) >= stream_length;
        ctr      <= '0;
      end

      // advance the step counter
      if (state == S_HDR && push_ok) ctr <= ctr + CW'(1);
      if (state == S_CHECK) ctr <= '0;
      if (state == S_LOAD) ctr <= (ctr == CW'(LOOKAHEAD_BYTES)) ? '0 : ctr + CW'(1);
      if (state == S_SCAN) ctr <= ctr + CW'(1);

      if (state == S_PICK) begin
        code_pos <= code_pos + (best_any ? 32'(best_len) : 32'd1);
        tok_i    <= '0;
      end
      if (state == S_EMIT && push_ok) tok_i <= tok_i + 2'd1;

      // output register drains, pending byte moves up on each push
      if (fin_fire || (push_fire && pend_valid)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (push_fire) pend_valid <= 1'b1;
      if (fin_fire)  pend_valid <= 1'b0;
    end
  end

  // -------- payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept && received == 32'd0) hdr_len <= stream_length;
    if (rd_en) ctr_d <= ctr;
    if (state == S_CHECK) begin
      maxlen_q <= (avail < 32'(LOOKAHEAD_BYTES)) ? LW'(avail) : LW'(LOOKAHEAD_BYTES);
      n_q      <= (code_pos >= 32'(WINDOW_BYTES)) ? OW'(WINDOW_BYTES) : OW'(code_pos);
      start_q  <= (code_pos >= 32'(WINDOW_BYTES)) ? code_pos - 32'(WINDOW_BYTES) : 32'd0;
    end
    if (state == S_PICK) begin
      if (best_any && best_off <= OFF_W'(SHORT_MAX_OFF) && best_len <= LW'(SHORT_MAX_LEN)) begin
        tok[0] <= SHORT_BASE | (8'(best_len - LW'(MIN_RUN)) << 1);
        tok[1] <= best_off[7:0];
        tok[2] <= '0;
        tok[3] <= '0;
        tok_n  <= 3'd2;
      end else if (best_any) begin
        tok[0] <= LONG_MARK;
        tok[1] <= 8'(best_len - LW'(MIN_RUN));
        tok[2] <= best_off[15:8];
        tok[3] <= best_off[7:0];
        tok_n  <= 3'd4;
      end else if (lit_byte < LIT_ESC) begin
        tok[0] <= lit_byte;
        tok[1] <= '0;
        tok[2] <= '0;
        tok[3] <= '0;
        tok_n  <= 3'd1;
      end else begin
        tok[0] <= LIT_ESC;
        tok[1] <= lit_byte;
        tok[2] <= '0;
        tok[3] <= '0;
        tok_n  <= 3'd2;
      end
    end
    if (push_fire) begin
      pend_data <= push_data;
      if (pend_valid) begin
        m_axis_tdata    <= pend_data;
        m_axis_tlast    <= 1'b0;
        m_axis_tuser[0] <= 1'b0;
      end
    end
    if (fin_fire) begin
      m_axis_tdata    <= pend_data;
      m_axis_tlast    <= 1'b1;
      m_axis_tuser[0] <= final_q;
    end
  end

  // -------- match cell row: window byte of data index ctr_d starts a run
  assign inject = '{alive: ctr_d < CW'(n_q), off: OFF_W'(n_q) - OFF_W'(ctr_d)};

  lzbt_row #(
    .LOOKAHEAD_BYTES (LOOKAHEAD_BYTES)
  ) u_row (
    .clk      (clk),
    .rst      (rst),
    .clear    (row_clear),
    .shift_en (rd_valid && state == S_LOAD),
    .shift_in (rd_data),
    .maxlen   (maxlen_q),
    .b_valid  (rd_valid && state == S_SCAN),
    .b        (rd_data),
    .inject   (inject),
    .lit_byte (lit_byte),
    .best_any (best_any),
    .best_len (best_len),
    .best_off (best_off)
  );

  // -------- checks
  a_pos_order: assert property (@(posedge clk) disable iff (rst)
    code_pos <= received)
    else $error("coding position ran past received bytes");

  a_tok_index: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> 3'(tok_i) < tok_n)
    else $error("token byte index out of range");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
    else $error("stream end without run end");

  a_idle_flushed: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !pend_valid)
    else $error("pending byte left when idle");

endmodule

`default_nettype wire

// ===== sim/lz77_byte_token_encoder_core_tb.sv =====
// ----------------------------------------------------------------------------
// lz77_byte_token_encoder_core_tb: self-checking bench for the LZ77 encoder
// Drives one job of uncompressed bytes through the stream input, predicts
// the header and token bytes with a behavioral encoder, and compares every
// output request field by field under random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module lz77_byte_token_encoder_core_tb
  import lzbt_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN = WINDOW_BYTES_DEF;
  localparam int LA  = LOOKAHEAD_BYTES_DEF;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int RANDOM_BYTES = 70;

  // One predicted output byte.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       fin;
  } enc_byte_t;

  // Directed stimulus row: n < 0 means the predictor supplies the bytes,
  // otherwise n bytes are typed in hdr, first byte in the top bits.
  typedef struct packed {
    logic [7:0]  data;
    int          n;
    logic [39:0] hdr;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic [0:0]  m_axis_tuser;

  lz77_byte_token_encoder_core uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser)
  );

  always #1 clk = ~clk;

  // Encoder state mirror.
  logic [7:0]  win_ring [WIN];
  logic [7:0]  ahead_ring [LA];
  logic [31:0] rcv_count = '0;
  logic [31:0] code_pos = '0;
  logic [31:0] job_len = 32'd1;

  enc_byte_t   step_bytes [$];   // bytes produced by the current request
  enc_byte_t   pending_bytes [$]; // bytes still owed by the encoder
  logic [7:0]  sent_log [$];

  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_count = 0;
  int tokens_seen = 0;
  int requests_sent = 0;

  function automatic logic [7:0] byte_at(logic [31:0] p);
    if (p >= code_pos) return ahead_ring[p % LA];
    return win_ring[p % WIN];
  endfunction

  function automatic void put_byte(logic [7:0] b);
    enc_byte_t e;
    e.data = b;
    e.last = 1'b0;
    e.fin  = 1'b0;
    step_bytes.push_back(e);
  endfunction

  // Code one greedy token at code_pos, searching no further than limit.
  function automatic void code_token(logic [31:0] limit);
    logic [31:0] pos, avail, maxlen, start, best, off, len, used;
    pos    = code_pos;
    avail  = limit - pos;
    maxlen = (avail < LA) ? avail : LA;
    start  = (pos >= WIN) ? pos - WIN : 32'd0;
    best   = 0;
    off    = 0;
    for (logic [31:0] i = start; i < pos; i++) begin
      len = 0;
      while (len < maxlen && byte_at(i + len) == byte_at(pos + len)) len++;
      // strict compare keeps the oldest candidate on a tie
      if (len >= MIN_RUN && len > best) begin
        best = len;
        off  = pos - i;
      end
    end
    if (best >= MIN_RUN) begin
      if (off <= SHORT_MAX_OFF && best <= SHORT_MAX_LEN) begin
        put_byte(SHORT_BASE | 8'((best - MIN_RUN) << 1));
        put_byte(off[7:0]);
      end else begin
        put_byte(LONG_MARK);
        put_byte(8'(best - MIN_RUN));
        put_byte(off[15:8]);
        put_byte(off[7:0]);
      end
      used = best;
    end else begin
      if (byte_at(pos) < LIT_ESC) begin
        put_byte(byte_at(pos));
      end else begin
        put_byte(LIT_ESC);
        put_byte(byte_at(pos));
      end
      used = 1;
    end
    for (logic [31:0] k = 0; k < used; k++)
      win_ring[(pos + k) % WIN] = ahead_ring[(pos + k) % LA];
    code_pos = pos + used;
    tokens_seen++;
  endfunction

  // Advance the mirror by one accepted input byte; results land in step_bytes.
  function automatic void encode_step(logic [7:0] b);
    logic is_final;
    step_bytes.delete();
    if (rcv_count >= job_len) return;  // job over: drop the byte
    if (rcv_count == 0) begin
      put_byte(HDR_MAGIC);
      put_byte(job_len[31:24]);
      put_byte(job_len[23:16]);
      put_byte(job_len[15:8]);
      put_byte(job_len[7:0]);
    end
    ahead_ring[rcv_count % LA] = b;
    rcv_count++;
    is_final = rcv_count >= job_len;
    if (is_final) begin
      while (code_pos < rcv_count) code_token(rcv_count);
    end else begin
      while (rcv_count - code_pos >= LA) code_token(rcv_count);
    end
    if (step_bytes.size() > 0) begin
      step_bytes[$].last = 1'b1;
      step_bytes[$].fin  = is_final;
    end
  endfunction

  // Send one request; n >= 0 replaces the predicted bytes with typed ones.
  task automatic send_byte(input logic [7:0] b, input int n, input logic [39:0] hdr);
    enc_byte_t e;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      while ($urandom_range(99) < send_idle_pct + 20) @(posedge clk);
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    encode_step(b);
    sent_log.push_back(b);
    requests_sent++;
    if (n < 0) begin
      foreach (step_bytes[i]) pending_bytes.push_back(step_bytes[i]);
    end else begin
      for (int i = 0; i < n; i++) begin
        e.data = hdr[39 - 8*i -: 8];
        e.last = (i == n - 1);
        e.fin  = 1'b0;
        pending_bytes.push_back(e);
      end
    end
  endtask

  // Drain, hold off for the quiet-input latency, then write the length.
  task automatic write_length(input logic [31:0] v);
    s_axis_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    job_len = v;
  endtask

  // Output side: random stall, then check each accepted request.
  always @(posedge clk) begin
    enc_byte_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected output byte %02h", m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_bytes.pop_front();
        if (m_axis_tdata !== want.data) begin
          $error("out_byte: expected %02h, got %02h", want.data, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("run_last: expected %0b, got %0b", want.last, m_axis_tlast);
          fail_count++;
        end
        if (m_axis_tuser[0] !== want.fin) begin
          $error("stream_end: expected %0b, got %0b", want.fin, m_axis_tuser[0]);
          fail_count++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Hard stop if the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[lz77_byte_token_encoder_core] ERROR");
      $finish;
    end
  end

  stim_row_t directed [25] = '{
    // zero length: both requests dropped
    '{8'h55, 0, 40'h0},
    '{8'hAA, 0, 40'h0},
    // first byte of the job: header only, lookahead not yet full
    '{8'h00, 5, 40'h01FFFFFFFF},
    '{8'hFF, -1, 40'h0}, '{8'h7F, -1, 40'h0}, '{8'h80, -1, 40'h0},
    '{8'h01, -1, 40'h0},
    '{8'h61, -1, 40'h0}, '{8'h61, -1, 40'h0}, '{8'h61, -1, 40'h0},
    '{8'h61, -1, 40'h0}, '{8'h61, -1, 40'h0}, '{8'h61, -1, 40'h0},
    '{8'h61, -1, 40'h0}, '{8'h61, -1, 40'h0}, '{8'h61, -1, 40'h0},
    '{8'h61, -1, 40'h0}, '{8'h61, -1, 40'h0}, '{8'h61, -1, 40'h0},
    '{8'h61, -1, 40'h0}, '{8'h61, -1, 40'h0},
    '{8'hFF, -1, 40'h0}, '{8'h7F, -1, 40'h0}, '{8'h00, -1, 40'h0},
    '{8'hFE, -1, 40'h0}
  };

  initial begin
    int sent, seg_len, back_off, kind;
    logic [7:0] fill;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part; the length is zero for the first two rows.
    write_length(32'd0);
    foreach (directed[i]) begin
      if (i == 2) write_length(32'hFFFF_FFFF);
      send_byte(directed[i].data, directed[i].n, directed[i].hdr);
    end

    // Random part: copies of earlier data, byte runs and noise literals.
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      if (sent == 0) begin
        send_idle_pct = 11; recv_stall_pct = 57;
      end else if (sent >= RANDOM_BYTES / 3 && send_idle_pct == 11) begin
        write_length(32'h8000_0000);
        send_idle_pct = 57; recv_stall_pct = 11;
      end else if (sent >= 2 * RANDOM_BYTES / 3 && send_idle_pct == 57) begin
        write_length(32'hFFFF_FFFE);
        send_idle_pct = 0; recv_stall_pct = 0;
      end
      kind    = $urandom_range(9);
      seg_len = $urandom_range(3, 20);
      if (kind < 5) begin
        // repeat a slice of the past, sometimes from far back
        back_off = $urandom_range(1, sent_log.size());
        for (int k = 0; k < seg_len; k++)
          send_byte(sent_log[sent_log.size() - back_off], -1, 40'h0);
      end else if (kind < 7) begin
        fill = 8'($urandom_range(255));
        for (int k = 0; k < seg_len; k++) send_byte(fill, -1, 40'h0);
      end else begin
        for (int k = 0; k < seg_len; k++) send_byte(8'($urandom_range(255)), -1, 40'h0);
      end
      sent += seg_len;
    end

    // A length one above the bytes received ends the job at the next byte,
    // which flushes the lookahead; the bytes after it are dropped.
    write_length(rcv_count + 32'd1);
    for (int k = 0; k < 4; k++) send_byte(8'($urandom_range(255)), -1, 40'h0);
    s_axis_tvalid <= 1'b0;

    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);

    $display("sent %0d requests, coded %0d tokens over lengths 0, 2^31, max and a final flush",
             requests_sent, tokens_seen);
    $display("idling swept sender/receiver 11/57, 57/11 and 0/0 percent");
    if (fail_count == 0) begin
      $display("[lz77_byte_token_encoder_core] OK");
    end else begin
      $display("[lz77_byte_token_encoder_core] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
